/* rtl/core/elfm_pkg.sv */
// Shared types, constants and helpers for the edit list frame mapper.
// Used by elfm_seg_ram, elfm_alu and edit_list_frame_mapper_core.
`default_nettype none

package elfm_pkg;

    localparam int MAX_SEGMENTS = 64;
    localparam int IDX_W        = $clog2(MAX_SEGMENTS);
    // Search bounds run up to the segment count plus one.
    localparam int CNT_W        = $clog2(MAX_SEGMENTS + 2);
    localparam int FRAME_W      = 32;
    localparam int SRC_W        = 8;
    localparam int ACC_W        = 36;
    localparam int OP_W         = 3;
    localparam int STATUS_W     = 3;
    localparam int PORT_IDX_W   = 6;
    localparam int CFG_ADDR_W   = 1;

    localparam logic [CFG_ADDR_W-1:0] CFG_USE_CUT  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_FIRST_GF = 1'b1;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR   = 3'd0,
        OP_APPEND  = 3'd1,
        OP_LOOKUP  = 3'd2,
        OP_ENTRY   = 3'd3,
        OP_REVERSE = 3'd4
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK     = 3'd0,
        STAT_EMPTY  = 3'd1,
        STAT_INDEX  = 3'd2,
        STAT_FULL   = 3'd3,
        STAT_REJECT = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_APP_LEN,
        ST_APP_END,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_EQ_RD,
        ST_EQ_CMP,
        ST_ENT_RD,
        ST_ENT_T,
        ST_ENT_F,
        ST_CLAMP_HI,
        ST_CLAMP_LO,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [FRAME_W-1:0] start;
        logic [SRC_W-1:0]   source;
        logic [FRAME_W-1:0] in_frame;
        logic [FRAME_W-1:0] out_frame;
    } seg_entry_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] addr;
        seg_entry_t       entry;
    } ram_wr_t;

    typedef struct packed {
        logic             re;
        logic [IDX_W-1:0] addr;
    } ram_rd_t;

    function automatic logic [ACC_W-1:0] sx(input logic [FRAME_W-1:0] v);
        sx = {{(ACC_W - FRAME_W){v[FRAME_W-1]}}, v};
    endfunction

    // Saturates a wide signed value to the 32-bit signed range.
    function automatic logic [ACC_W-1:0] sat_acc(input logic [ACC_W-1:0] v);
        logic [ACC_W-FRAME_W:0] top;
        top = v[ACC_W-1:FRAME_W-1];
        if ((&top) || !(|top)) begin
            sat_acc = v;
        end else if (v[ACC_W-1]) begin
            sat_acc = sx({1'b1, {(FRAME_W - 1){1'b0}}});
        end else begin
            sat_acc = sx({1'b0, {(FRAME_W - 1){1'b1}}});
        end
    endfunction

endpackage

`default_nettype wire

/* rtl/core/elfm_seg_ram.sv */
// Segment memory of the edit list: one write port, one registered read port.
// Depends on elfm_pkg for the entry layout and depth.
`default_nettype none

module elfm_seg_ram (
    input  wire logic                clk,
    input  wire elfm_pkg::ram_wr_t   wr,
    input  wire elfm_pkg::ram_rd_t   rd,
    output elfm_pkg::seg_entry_t     rdata
);
    import elfm_pkg::*;

    seg_entry_t mem [MAX_SEGMENTS];
    seg_entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.addr] <= wr.entry;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd.re)
        begin
            rdata_reg <= mem[rd.addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* rtl/core/elfm_alu.sv */
// Shared adder and comparator used for the frame arithmetic of the mapper.
// Depends on elfm_pkg for the datapath width.
`default_nettype none

module elfm_alu (
    input  wire logic [elfm_pkg::ACC_W-1:0] a,
    input  wire logic [elfm_pkg::ACC_W-1:0] b,
    input  wire logic                       sub,
    input  wire logic                       cin,
    output logic [elfm_pkg::ACC_W-1:0]      sum,
    output logic                            is_zero,
    output logic                            is_neg,
    output logic                            is_pos
);
    import elfm_pkg::*;

    logic [ACC_W-1:0] b_op;

    always_comb
    begin
        b_op    = sub ? ~b : b;
        sum     = a + b_op + ACC_W'(cin);
        is_zero = (sum == '0);
        is_neg  = sum[ACC_W-1];
        is_pos  = !is_neg && !is_zero;
    end

endmodule

`default_nettype wire

/* rtl/core/edit_list_frame_mapper_core.sv */
// Top level of the edit list frame mapper: sequencer, state and result register.
// Depends on elfm_pkg, elfm_seg_ram and elfm_alu.
//
//   Channel   Signals                                         Direction
//   input     in_valid/in_ready, op .. cut_out                into block
//   result    out_valid/out_ready, status .. sequence_end    out of block
//   config    cfg_we, cfg_addr, cfg_wdata                     into block
//
// One item at a time: a new item is taken only in the idle state, after the last one
// has left ST_DONE. Frame lookup runs a binary search over the segment starts. Frame
// arithmetic goes through one shared adder, and every segment read goes through the
// single registered read port of the segment memory.
// Reset empties the list and sets the running end to one; no memory clearing.
// A finished result waits in the output register while the next item is taken.
`default_nettype none

module edit_list_frame_mapper_core (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic [elfm_pkg::OP_W-1:0]             op,
    input  wire logic signed [elfm_pkg::FRAME_W-1:0]   frame,
    input  wire logic [elfm_pkg::PORT_IDX_W-1:0]       entry_index,
    input  wire logic [elfm_pkg::SRC_W-1:0]            source_id,
    input  wire logic signed [elfm_pkg::FRAME_W-1:0]   range_start,
    input  wire logic signed [elfm_pkg::FRAME_W-1:0]   range_end,
    input  wire logic signed [elfm_pkg::FRAME_W-1:0]   cut_in,
    input  wire logic signed [elfm_pkg::FRAME_W-1:0]   cut_out,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic [elfm_pkg::STATUS_W-1:0]              status,
    output logic [elfm_pkg::PORT_IDX_W-1:0]            found_index,
    output logic [elfm_pkg::SRC_W-1:0]                 found_source,
    output logic signed [elfm_pkg::FRAME_W-1:0]        frame_out,
    output logic signed [elfm_pkg::FRAME_W-1:0]        sequence_end,
    input  wire logic                                  cfg_we,
    input  wire logic [elfm_pkg::CFG_ADDR_W-1:0]       cfg_addr,
    input  wire logic [elfm_pkg::FRAME_W-1:0]          cfg_wdata
);
    import elfm_pkg::*;

    // Control state.
    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   seg_count_reg, seg_count_next;
    logic [FRAME_W-1:0] running_end_reg, running_end_next;
    logic               out_valid_reg, out_valid_next;
    logic               use_cut_reg;
    logic [FRAME_W-1:0] first_gf_reg;

    // Working registers.
    logic [OP_W-1:0]    op_reg, op_next;
    logic [FRAME_W-1:0] frame_reg, frame_next;
    logic [SRC_W-1:0]   src_in_reg, src_in_next;
    logic [FRAME_W-1:0] seg_s_reg, seg_s_next;
    logic [FRAME_W-1:0] seg_e_reg, seg_e_next;
    logic [CNT_W-1:0]   lo_reg, lo_next;
    logic [CNT_W-1:0]   hi_reg, hi_next;
    logic [CNT_W-1:0]   mid_reg, mid_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    status_t            stat_reg, stat_next;
    logic [SRC_W-1:0]   res_src_reg, res_src_next;

    // Output register.
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic [PORT_IDX_W-1:0] found_index_reg, found_index_next;
    logic [SRC_W-1:0]      found_source_reg, found_source_next;
    logic [FRAME_W-1:0]    frame_out_reg, frame_out_next;
    logic [FRAME_W-1:0]    seq_end_reg, seq_end_next;

    // Shared unit and memory hookup.
    logic [ACC_W-1:0] unit_a, unit_b, unit_sum;
    logic             unit_sub, unit_cin, unit_zero, unit_neg, unit_pos;
    ram_wr_t          ram_wr;
    ram_rd_t          ram_rd;
    seg_entry_t       ram_rdata;

    logic [CNT_W:0]     mid_sum;
    logic [CNT_W-1:0]   mid_calc;
    logic [FRAME_W-1:0] bnd;
    logic               reject;

    elfm_seg_ram u_seg_ram (
        .clk   (clk),
        .wr    (ram_wr),
        .rd    (ram_rd),
        .rdata (ram_rdata)
    );

    elfm_alu u_alu (
        .a       (unit_a),
        .b       (unit_b),
        .sub     (unit_sub),
        .cin     (unit_cin),
        .sum     (unit_sum),
        .is_zero (unit_zero),
        .is_neg  (unit_neg),
        .is_pos  (unit_pos)
    );

    assign in_ready     = (state_reg == ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign found_index  = found_index_reg;
    assign found_source = found_source_reg;
    assign frame_out    = frame_out_reg;
    assign sequence_end = seq_end_reg;

    always_comb
    begin
        state_next        = state_reg;
        seg_count_next    = seg_count_reg;
        running_end_next  = running_end_reg;
        out_valid_next    = out_valid_reg;
        op_next           = op_reg;
        frame_next        = frame_reg;
        src_in_next       = src_in_reg;
        seg_s_next        = seg_s_reg;
        seg_e_next        = seg_e_reg;
        lo_next           = lo_reg;
        hi_next           = hi_reg;
        mid_next          = mid_reg;
        idx_next          = idx_reg;
        acc_next          = acc_reg;
        stat_next         = stat_reg;
        res_src_next      = res_src_reg;
        status_next       = status_reg;
        found_index_next  = found_index_reg;
        found_source_next = found_source_reg;
        frame_out_next    = frame_out_reg;
        seq_end_next      = seq_end_reg;

        unit_a   = sx(frame_reg);
        unit_b   = '0;
        unit_sub = 1'b1;
        unit_cin = 1'b1;

        ram_wr.we    = 1'b0;
        ram_wr.addr  = IDX_W'(seg_count_reg);
        ram_wr.entry = '{start: running_end_reg, source: src_in_reg,
                         in_frame: seg_s_reg, out_frame: seg_e_reg};
        ram_rd.re    = 1'b0;
        ram_rd.addr  = idx_reg;

        mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg};
        mid_calc = mid_sum[CNT_W:1];
        bnd      = running_end_reg;
        reject   = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_next      = op;
                    frame_next   = frame;
                    src_in_next  = source_id;
                    seg_s_next   = use_cut_reg ? cut_in : range_start;
                    seg_e_next   = use_cut_reg ? cut_out : range_end;
                    stat_next    = STAT_OK;
                    idx_next     = '0;
                    res_src_next = '0;
                    acc_next     = '0;
                    lo_next      = '0;
                    hi_next      = seg_count_reg + CNT_W'(1);
                    state_next   = ST_DONE;
                    unique case (op)
                        OP_CLEAR:
                        begin
                            seg_count_next   = '0;
                            running_end_next = first_gf_reg;
                        end
                        OP_APPEND:
                        begin
                            if (seg_count_reg == CNT_W'(MAX_SEGMENTS))
                            begin
                                stat_next = STAT_FULL;
                            end
                            else
                            begin
                                state_next = ST_APP_LEN;
                            end
                        end
                        OP_LOOKUP:
                        begin
                            if (seg_count_reg == '0)
                            begin
                                stat_next = STAT_EMPTY;
                            end
                            else
                            begin
                                state_next = ST_SRCH_RD;
                            end
                        end
                        OP_ENTRY, OP_REVERSE:
                        begin
                            if (seg_count_reg == '0)
                            begin
                                stat_next = STAT_EMPTY;
                            end
                            else if (int'(entry_index) >= int'(seg_count_reg))
                            begin
                                stat_next = STAT_INDEX;
                            end
                            else
                            begin
                                idx_next   = IDX_W'(entry_index);
                                state_next = ST_ENT_RD;
                            end
                        end
                        default:
                        begin
                            stat_next = STAT_OK;
                        end
                    endcase
                end
            end

            ST_APP_LEN:
            begin
                // Length minus one; the missing one rides on the carry in of ST_APP_END.
                unit_a     = sx(seg_e_reg);
                unit_b     = sx(seg_s_reg);
                acc_next   = unit_sum;
                state_next = ST_APP_END;
            end

            ST_APP_END:
            begin
                unit_a   = sx(running_end_reg);
                unit_b   = acc_reg;
                unit_sub = 1'b0;
                unit_cin = 1'b1;
                reject   = (acc_reg[ACC_W-1] && !(&acc_reg))
                        || (!unit_sum[ACC_W-1] && (|unit_sum[ACC_W-2:FRAME_W-1]));
                if (reject)
                begin
                    stat_next = STAT_REJECT;
                    acc_next  = '0;
                end
                else
                begin
                    ram_wr.we        = 1'b1;
                    idx_next         = IDX_W'(seg_count_reg);
                    res_src_next     = src_in_reg;
                    acc_next         = sx(running_end_reg);
                    seg_count_next   = seg_count_reg + CNT_W'(1);
                    running_end_next = unit_sum[FRAME_W-1:0];
                end
                state_next = ST_DONE;
            end

            ST_SRCH_RD:
            begin
                if (lo_reg < hi_reg)
                begin
                    mid_next    = mid_calc;
                    ram_rd.re   = (mid_calc < seg_count_reg);
                    ram_rd.addr = IDX_W'(mid_calc);
                    state_next  = ST_SRCH_CMP;
                end
                else
                begin
                    state_next = ST_EQ_RD;
                end
            end

            ST_SRCH_CMP:
            begin
                // The boundary past the last segment is the running end.
                bnd    = (mid_reg < seg_count_reg) ? ram_rdata.start : running_end_reg;
                unit_b = sx(bnd);
                if (unit_pos)
                begin
                    lo_next = mid_reg + CNT_W'(1);
                end
                else
                begin
                    hi_next = mid_reg;
                end
                state_next = ST_SRCH_RD;
            end

            ST_EQ_RD:
            begin
                unit_b = sx(running_end_reg);
                if (lo_reg > seg_count_reg || unit_zero)
                begin
                    idx_next   = IDX_W'(seg_count_reg - CNT_W'(1));
                    state_next = ST_ENT_RD;
                end
                else
                begin
                    ram_rd.re   = (lo_reg < seg_count_reg);
                    ram_rd.addr = IDX_W'(lo_reg);
                    state_next  = ST_EQ_CMP;
                end
            end

            ST_EQ_CMP:
            begin
                bnd    = (lo_reg < seg_count_reg) ? ram_rdata.start : running_end_reg;
                unit_b = sx(bnd);
                if (unit_zero)
                begin
                    idx_next = IDX_W'(lo_reg);
                end
                else if (lo_reg == '0)
                begin
                    idx_next = '0;
                end
                else
                begin
                    idx_next = IDX_W'(lo_reg - CNT_W'(1));
                end
                state_next = ST_ENT_RD;
            end

            ST_ENT_RD:
            begin
                ram_rd.re   = 1'b1;
                ram_rd.addr = idx_reg;
                state_next  = ST_ENT_T;
            end

            ST_ENT_T:
            begin
                res_src_next = ram_rdata.source;
                if (op_reg == OP_REVERSE)
                begin
                    unit_a   = sx(ram_rdata.start);
                    unit_b   = sx(frame_reg);
                    unit_sub = 1'b0;
                    unit_cin = 1'b0;
                end
                else
                begin
                    unit_b = sx(ram_rdata.start);
                end
                acc_next   = unit_sum;
                state_next = ST_ENT_F;
            end

            ST_ENT_F:
            begin
                unit_a = acc_reg;
                unit_b = sx(ram_rdata.in_frame);
                if (op_reg != OP_REVERSE)
                begin
                    unit_sub = 1'b0;
                    unit_cin = 1'b0;
                end
                if (op_reg == OP_LOOKUP)
                begin
                    acc_next   = unit_sum;
                    state_next = ST_CLAMP_HI;
                end
                else
                begin
                    acc_next   = sat_acc(unit_sum);
                    state_next = ST_DONE;
                end
            end

            ST_CLAMP_HI:
            begin
                unit_a = acc_reg;
                unit_b = sx(ram_rdata.out_frame);
                if (unit_pos)
                begin
                    acc_next = sx(ram_rdata.out_frame);
                end
                state_next = ST_CLAMP_LO;
            end

            ST_CLAMP_LO:
            begin
                // The lower bound wins when a zero-length segment has out below in.
                unit_a = acc_reg;
                unit_b = sx(ram_rdata.in_frame);
                if (unit_neg)
                begin
                    acc_next = sx(ram_rdata.in_frame);
                end
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next    = 1'b1;
                    status_next       = stat_reg;
                    found_index_next  = PORT_IDX_W'(idx_reg);
                    found_source_next = res_src_reg;
                    frame_out_next    = acc_reg[FRAME_W-1:0];
                    seq_end_next      = running_end_reg;
                    state_next        = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            seg_count_reg   <= '0;
            running_end_reg <= FRAME_W'(1);
            out_valid_reg   <= 1'b0;
            use_cut_reg     <= 1'b1;
            first_gf_reg    <= FRAME_W'(1);
        end
        else
        begin
            state_reg       <= state_next;
            seg_count_reg   <= seg_count_next;
            running_end_reg <= running_end_next;
            out_valid_reg   <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    CFG_USE_CUT:  use_cut_reg  <= cfg_wdata[0];
                    CFG_FIRST_GF: first_gf_reg <= cfg_wdata;
                    default:      use_cut_reg  <= use_cut_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg           <= op_next;
        frame_reg        <= frame_next;
        src_in_reg       <= src_in_next;
        seg_s_reg        <= seg_s_next;
        seg_e_reg        <= seg_e_next;
        lo_reg           <= lo_next;
        hi_reg           <= hi_next;
        mid_reg          <= mid_next;
        idx_reg          <= idx_next;
        acc_reg          <= acc_next;
        stat_reg         <= stat_next;
        res_src_reg      <= res_src_next;
        status_reg       <= status_next;
        found_index_reg  <= found_index_next;
        found_source_reg <= found_source_next;
        frame_out_reg    <= frame_out_next;
        seq_end_reg      <= seq_end_next;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        seg_count_reg <= CNT_W'(MAX_SEGMENTS))
        else $error("segment count beyond capacity");

    a_probe_window: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SRCH_CMP |->
            (lo_reg <= mid_reg && mid_reg < hi_reg
             && hi_reg <= seg_count_reg + CNT_W'(1)))
        else $error("search probe outside its window");

    a_entry_valid: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ENT_RD |-> CNT_W'(idx_reg) < seg_count_reg)
        else $error("entry read beyond the list");

    a_end_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_valid && in_ready && op == OP_CLEAR) |=>
            $signed(running_end_reg) >= $signed($past(running_end_reg)))
        else $error("running end moved back without a clear");
`endif

endmodule

`default_nettype wire
